FILE: design/icmpfb_pkg.sv
// Shared types, constants and checksum fold for the ICMP echo-request frame builder.
// No dependencies; used by icmpfb_serializer and icmp_echo_request_frame_builder.
package icmpfb_pkg;

   localparam int unsigned BEAT_W     = 64;
   localparam int unsigned FRAME_W    = 576;
   localparam int unsigned REQ_DATA_W = 360;
   localparam int unsigned BYTES_W    = 4;
   localparam int unsigned CNT_W      = 4;

   localparam logic       CMD_V4 = 1'b0;
   localparam logic       CMD_V6 = 1'b1;

   localparam logic [15:0] ETH_TYPE_V4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_V6 = 16'h86dd;
   localparam logic [7:0]  IP4_VER_IHL = 8'h45;
   localparam logic [15:0] IP4_TOT_LEN = 16'd36;
   localparam logic [7:0]  IP4_PROTO   = 8'h01;
   localparam logic [31:0] IP6_VER_TC  = 32'h6000_0000;
   localparam logic [15:0] IP6_PAY_LEN = 16'd16;
   localparam logic [7:0]  IP6_NXT_HDR = 8'd58;
   localparam logic [7:0]  ICMP4_TYPE  = 8'h08;
   localparam logic [7:0]  ICMP6_TYPE  = 8'h80;
   localparam logic [63:0] ICMP_PAYLOAD = 64'h0001_0203_fffe_fdfc;

   // fixed IPv4 header words: version/IHL/TOS + total length
   localparam logic [15:0] IP4_FIXED_SUM = 16'h4524;
   // ICMPv6 fixed words plus pseudo-header length and next header
   localparam logic [20:0] ICMP6_FIXED_SUM = 21'h02_8048;
   localparam logic [31:0] ICMP4_SUM = 32'h0002_07fe;

   // last beat index and byte count per frame kind
   localparam logic [CNT_W-1:0]   LAST_BEAT_V4 = 4'd6;
   localparam logic [CNT_W-1:0]   LAST_BEAT_V6 = 4'd8;
   localparam logic [BYTES_W-1:0] LAST_BYTES_V4 = 4'd2;
   localparam logic [BYTES_W-1:0] LAST_BYTES_V6 = 4'd6;
   localparam logic [BYTES_W-1:0] FULL_BYTES    = 4'd8;

   typedef struct packed {
      logic        cmd;
      logic [47:0] mac_destination;
      logic [47:0] mac_source;
      logic [63:0] ip_source_high;
      logic [63:0] ip_source_low;
      logic [63:0] ip_destination_high;
      logic [63:0] ip_destination_low;
      logic [7:0]  hop_count;
   } req_type;

   typedef struct packed {
      logic               v6;
      logic [FRAME_W-1:0] bits;
   } frame_type;

   // ones' complement of the 16-bit sum, end-around carry folded twice
   function automatic logic [15:0] fold_csum(input logic [31:0] s);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
      f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
      return ~f2[15:0];
   endfunction

   localparam logic [15:0] ICMP4_CSUM = fold_csum(ICMP4_SUM);

endpackage

FILE: design/icmp_echo_request_frame_builder.sv
// Top level: checksum pipeline and frame assembly feeding the beat serializer.
// Depends on icmpfb_pkg and icmpfb_serializer.
//
//  channel | dir | tdata                       | tuser      | tlast
//  req_    | in  | request fields (360 bits)   | cmd        | -
//  rsp_    | out | beat_data (64 bits)         | beat_bytes | beat_last
//
// Four register stages (pair sums, quad sums, total, fold + assembly) then
// the serializer buffer and the output register lie between the request
// transaction and the first beat. Output runs 7 beats (IPv4) or 9 beats
// (IPv6) of the 64-bit port per request, one beat per cycle while rsp_tready is high.
// Synchronous reset clears all valid bits. A stall holds each full stage;
// empty stages in front of it keep filling.
module icmp_echo_request_frame_builder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mac_destination, mac_source, ip_source_high, ip_source_low,
   // ip_destination_high, ip_destination_low, hop_count
   input  logic [icmpfb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                                req_tuser,   // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [icmpfb_pkg::BEAT_W-1:0]       rsp_tdata,   // beat_data
   output logic [icmpfb_pkg::BYTES_W-1:0]      rsp_tuser,   // beat_bytes
   output logic                                rsp_tlast    // beat_last
);

   icmpfb_pkg::req_type   req;
   icmpfb_pkg::req_type   s1_req_ff, s2_req_ff, s3_req_ff;
   logic                  s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic                  s1_v_in, s2_v_in, s3_v_in, s4_v_in;
   logic                  en1, en2, en3, en4, ser_ready;
   logic [16:0]           pair_in [8];
   logic [16:0]           pair_ff [8];
   logic [18:0]           q0_ff, q1_ff, v4sum_ff;
   logic [20:0]           raw_ff;
   logic [15:0]           csum;
   icmpfb_pkg::frame_type frame_in, frame_ff;

   always_comb begin
      req.cmd                 = req_tuser;
      req.mac_destination     = req_tdata[47:0];
      req.mac_source          = req_tdata[95:48];
      req.ip_source_high      = req_tdata[159:96];
      req.ip_source_low       = req_tdata[223:160];
      req.ip_destination_high = req_tdata[287:224];
      req.ip_destination_low  = req_tdata[351:288];
      req.hop_count           = req_tdata[359:352];
   end

   // stage enables, back to front
   always_comb begin
      en4 = !s4_v_ff || ser_ready;
      en3 = !s3_v_ff || en4;
      en2 = !s2_v_ff || en3;
      en1 = !s1_v_ff || en2;
      s1_v_in = en1 ? req_tvalid : s1_v_ff;
      s2_v_in = en2 ? s1_v_ff : s2_v_ff;
      s3_v_in = en3 ? s2_v_ff : s3_v_ff;
      s4_v_in = en4 ? s3_v_ff : s4_v_ff;
   end

   assign req_tready = en1;

   always_comb begin
      pair_in[0] = {1'b0, req.ip_source_high[63:48]} + {1'b0, req.ip_source_high[47:32]};
      pair_in[1] = {1'b0, req.ip_source_high[31:16]} + {1'b0, req.ip_source_high[15:0]};
      pair_in[2] = {1'b0, req.ip_source_low[63:48]} + {1'b0, req.ip_source_low[47:32]};
      pair_in[3] = {1'b0, req.ip_source_low[31:16]} + {1'b0, req.ip_source_low[15:0]};
      pair_in[4] = {1'b0, req.ip_destination_high[63:48]}
                 + {1'b0, req.ip_destination_high[47:32]};
      pair_in[5] = {1'b0, req.ip_destination_high[31:16]}
                 + {1'b0, req.ip_destination_high[15:0]};
      pair_in[6] = {1'b0, req.ip_destination_low[63:48]}
                 + {1'b0, req.ip_destination_low[47:32]};
      pair_in[7] = {1'b0, req.ip_destination_low[31:16]}
                 + {1'b0, req.ip_destination_low[15:0]};
   end

   always_comb begin
      csum = icmpfb_pkg::fold_csum({11'b0, raw_ff});
      frame_in.v6 = s3_req_ff.cmd;
      if (s3_req_ff.cmd == icmpfb_pkg::CMD_V6) begin
         frame_in.bits = {s3_req_ff.mac_destination, s3_req_ff.mac_source,
                          icmpfb_pkg::ETH_TYPE_V6, icmpfb_pkg::IP6_VER_TC,
                          icmpfb_pkg::IP6_PAY_LEN, icmpfb_pkg::IP6_NXT_HDR,
                          s3_req_ff.hop_count,
                          s3_req_ff.ip_source_high, s3_req_ff.ip_source_low,
                          s3_req_ff.ip_destination_high, s3_req_ff.ip_destination_low,
                          icmpfb_pkg::ICMP6_TYPE, 8'h00, csum, 32'h0,
                          icmpfb_pkg::ICMP_PAYLOAD, 16'h0};
      end else begin
         frame_in.bits = {s3_req_ff.mac_destination, s3_req_ff.mac_source,
                          icmpfb_pkg::ETH_TYPE_V4, icmpfb_pkg::IP4_VER_IHL, 8'h00,
                          icmpfb_pkg::IP4_TOT_LEN, 32'h0,
                          s3_req_ff.hop_count, icmpfb_pkg::IP4_PROTO, csum,
                          s3_req_ff.ip_source_low[31:0], s3_req_ff.ip_destination_low[31:0],
                          icmpfb_pkg::ICMP4_TYPE, 8'h00, icmpfb_pkg::ICMP4_CSUM, 32'h0,
                          icmpfb_pkg::ICMP_PAYLOAD, 176'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         s4_v_ff <= s4_v_in;
      end
      if (en1) begin
         s1_req_ff <= req;
         pair_ff   <= pair_in;
      end
      if (en2) begin
         s2_req_ff <= s1_req_ff;
         q0_ff     <= {2'b0, pair_ff[0]} + {2'b0, pair_ff[1]}
                    + {2'b0, pair_ff[2]} + {2'b0, pair_ff[3]};
         q1_ff     <= {2'b0, pair_ff[4]} + {2'b0, pair_ff[5]}
                    + {2'b0, pair_ff[6]} + {2'b0, pair_ff[7]};
         v4sum_ff  <= {2'b0, pair_ff[3]} + {2'b0, pair_ff[7]}
                    + {3'b0, icmpfb_pkg::IP4_FIXED_SUM}
                    + {3'b0, s1_req_ff.hop_count, icmpfb_pkg::IP4_PROTO};
      end
      if (en3) begin
         s3_req_ff <= s2_req_ff;
         if (s2_req_ff.cmd == icmpfb_pkg::CMD_V6) begin
            raw_ff <= {2'b0, q0_ff} + {2'b0, q1_ff} + icmpfb_pkg::ICMP6_FIXED_SUM;
         end else begin
            raw_ff <= {2'b0, v4sum_ff};
         end
      end
      if (en4) begin
         frame_ff <= frame_in;
      end
   end

   icmpfb_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .fr_valid   (s4_v_ff),
      .fr_ready   (ser_ready),
      .fr         (frame_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_s4_hold: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !ser_ready) |=> (s4_v_ff && $stable(frame_ff)))
      else $error("stalled frame changed");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !en4) |=> (s3_v_ff && $stable(raw_ff)))
      else $error("stalled checksum stage changed");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (!s1_v_ff && !s2_v_ff && !s3_v_ff && !s4_v_ff) |-> req_tready)
      else $error("empty pipeline not ready");

endmodule

FILE: design/icmpfb_serializer.sv
// Splits an assembled frame into 64-bit beats behind a registered output stage.
// Depends on icmpfb_pkg.
module icmpfb_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fr_valid,
   output logic                            fr_ready,
   input  icmpfb_pkg::frame_type           fr,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [icmpfb_pkg::BEAT_W-1:0]   rsp_tdata,  // beat_data
   output logic [icmpfb_pkg::BYTES_W-1:0]  rsp_tuser,  // beat_bytes
   output logic                            rsp_tlast   // beat_last
);

   logic [icmpfb_pkg::FRAME_W-1:0] buf_ff, buf_in;
   logic                           v6_ff, v6_in;
   logic [icmpfb_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           out_valid_ff, out_valid_in;
   logic [icmpfb_pkg::BEAT_W-1:0]  out_data_ff, out_data_in;
   logic [icmpfb_pkg::BYTES_W-1:0] out_bytes_ff, out_bytes_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_en;
   logic                           last_beat;

   always_comb begin
      out_en    = !out_valid_ff || rsp_tready;
      last_beat = (cnt_ff == (v6_ff ? icmpfb_pkg::LAST_BEAT_V6 : icmpfb_pkg::LAST_BEAT_V4));
      fr_ready  = !busy_ff || (out_en && last_beat);

      buf_in       = buf_ff;
      v6_in        = v6_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;

      if (out_en) begin
         out_valid_in = busy_ff;
         out_data_in  = buf_ff[icmpfb_pkg::FRAME_W-1 -: icmpfb_pkg::BEAT_W];
         out_last_in  = last_beat;
         if (last_beat) begin
            out_bytes_in = v6_ff ? icmpfb_pkg::LAST_BYTES_V6 : icmpfb_pkg::LAST_BYTES_V4;
         end else begin
            out_bytes_in = icmpfb_pkg::FULL_BYTES;
         end
         if (busy_ff) begin
            buf_in  = {buf_ff[icmpfb_pkg::FRAME_W-icmpfb_pkg::BEAT_W-1:0],
                       {icmpfb_pkg::BEAT_W{1'b0}}};
            cnt_in  = cnt_ff + 4'd1;
            busy_in = !last_beat;
         end
      end

      if (fr_valid && fr_ready) begin
         buf_in  = fr.bits;
         v6_in   = fr.v6;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
      buf_ff       <= buf_in;
      v6_ff        <= v6_in;
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_bytes_ff;
   assign rsp_tlast  = out_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= icmpfb_pkg::LAST_BEAT_V6))
      else $error("beat counter out of range");

   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_bytes_ff != icmpfb_pkg::FULL_BYTES)) |-> out_last_ff)
      else $error("partial beat not marked last");

   a_last_bytes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |->
         (out_bytes_ff == icmpfb_pkg::LAST_BYTES_V4 ||
          out_bytes_ff == icmpfb_pkg::LAST_BYTES_V6))
      else $error("bad byte count on last beat");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (fr_valid && fr_ready && busy_ff) |-> (out_en && last_beat))
      else $error("frame loaded over a busy buffer");

endmodule
